// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by pdh_datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/pdh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdh_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pdh_pkg;

   localparam int MAX_PARTICLES = 1024;
   localparam int MAX_BINS      = 64;
   localparam int ADDR_W        = $clog2(MAX_PARTICLES);
   localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
   localparam int BIN_W         = $clog2(MAX_BINS);
   localparam int NB_W          = 7;
   localparam int PAIR_W        = 20;
   localparam logic [PAIR_W-1:0] PAIR_MAX = '1;
   localparam logic [NB_W-1:0]   NB_MAX   = NB_W'(MAX_BINS);

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BINS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MAX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_SIZE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_DIAM = 3'd4;

   localparam logic [NB_W-1:0] NUM_BINS_RST  = 7'd64;
   localparam logic [30:0]     RANGE_MIN_RST = 31'd0;
   localparam logic [30:0]     RANGE_MAX_RST = 31'd327680;
   localparam logic [30:0]     BOX_SIZE_RST  = 31'd1048576;

   // quotient bits produced per divide
   localparam int DIV_CNT_W = 7;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MOD   = 7'd33;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SCALE = 7'd49;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_BIN   = 7'd39;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FRAC  = 7'd51;

   localparam int SQRT_CNT_W = 6;
   localparam logic [SQRT_CNT_W-1:0] SQRT_STEPS = 6'd32;

   typedef enum logic [2:0] {
      DIV_MODX,
      DIV_MODY,
      DIV_SCALE,
      DIV_BIN,
      DIV_FRAC
   } div_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LOAD,
      ST_MODX,
      ST_MODX_WAIT,
      ST_MODY,
      ST_MODY_WAIT,
      ST_MUL,
      ST_SQRT,
      ST_SQRT_WAIT,
      ST_SCALE,
      ST_SCALE_WAIT,
      ST_BIN_CHECK,
      ST_BIN_DIV,
      ST_BIN_WAIT,
      ST_BIN_READ,
      ST_BIN_WRITE,
      ST_NEXT,
      ST_FINISH,
      ST_RD_READ,
      ST_RD_DIV,
      ST_RD_WAIT,
      ST_RD_OUT
   } state_type;

   typedef struct packed {
      logic        accept;
      logic        read_store;
      logic        load_pair;
      logic        div_start;
      div_sel_type div_sel;
      logic        cap_ax;
      logic        cap_ay;
      logic        mul;
      logic        sqrt_start;
      logic        cap_dist;
      logic        dist_sat;
      logic        cap_scaled;
      logic        bin_prep;
      logic        cap_bin;
      logic        bin_rd;
      logic        bin_wr;
      logic        next_j;
      logic        store_done;
      logic        rd_start;
      logic        rd_read;
      logic        rsp_zero;
      logic        rsp_load;
      logic        next_k;
      logic        clear_all;
   } cmd_type;

   typedef struct packed {
      logic j_done;
      logic div_done;
      logic sqrt_done;
      logic scale_div;
      logic scale_zero;
      logic in_range;
      logic last;
      logic pairs_zero;
      logic k_last;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/pdh_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdh_div
// Restoring divider, one quotient bit per cycle, left-aligned dividend.
// ----------------------------------------------------------------------------
module pdh_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [63:0]                    dividend,
   input  logic [31:0]                    divisor,
   input  logic [pdh_pkg::DIV_CNT_W-1:0]  steps,
   output logic                           busy,
   output logic                           done,
   output logic [63:0]                    quotient,
   output logic [31:0]                    remainder
);
   import pdh_pkg::*;

   logic [63:0]          dvd_ff;
   logic [31:0]          rem_ff;
   logic [31:0]          dsr_ff;
   logic [63:0]          quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [32:0] part_in;
   logic [32:0] diff_in;
   logic        ge_in;

   assign part_in = {rem_ff, dvd_ff[63]};
   assign diff_in = part_in - {1'b0, dsr_ff};
   assign ge_in   = part_in >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[62:0], 1'b0};
         rem_ff <= ge_in ? diff_in[31:0] : part_in[31:0];
         quo_ff <= {quo_ff[62:0], ge_in};
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ===== rtl/pdh_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdh_sqrt
// Integer square root, one root bit per cycle, floored result.
// ----------------------------------------------------------------------------
module pdh_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [62:0] value,
   output logic        done,
   output logic [31:0] root
);
   import pdh_pkg::*;

   logic [63:0]           v_ff;
   logic [35:0]           rem_ff;
   logic [31:0]           root_ff;
   logic [SQRT_CNT_W-1:0] cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [35:0] rem_sh_in;
   logic [35:0] trial_in;
   logic        ge_in;

   assign rem_sh_in = {rem_ff[33:0], v_ff[63:62]};
   assign trial_in  = {2'b00, root_ff, 2'b01};
   assign ge_in     = rem_sh_in >= trial_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= SQRT_STEPS;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - SQRT_CNT_W'(1);
            if (cnt_ff == SQRT_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff    <= {1'b0, value};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         v_ff    <= {v_ff[61:0], 2'b00};
         rem_ff  <= ge_in ? (rem_sh_in - trial_in) : rem_sh_in;
         root_ff <= {root_ff[30:0], ge_in};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ===== rtl/pdh_datapath.sv =====
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pdh_datapath
// Particle stores, pair distance arithmetic, histogram memory and readout.
// ----------------------------------------------------------------------------
module pdh_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  pdh_pkg::cmd_type                 cmd,
   output pdh_pkg::sts_type                 sts,
   input  logic                             csr_wr,
   input  logic [pdh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_wdata,
   input  logic signed [31:0]               req_pos_x,
   input  logic signed [31:0]               req_pos_y,
   input  logic [23:0]                      req_diameter,
   input  logic                             req_last_particle,
   output logic [pdh_pkg::BIN_W-1:0]        rsp_bin_number,
   output logic [31:0]                      rsp_pair_fraction,
   output logic                             rsp_last_bin
);
   import pdh_pkg::*;

   // configuration
   logic [NB_W-1:0] num_bins_ff;
   logic [30:0]     range_min_ff;
   logic [30:0]     range_max_ff;
   logic [30:0]     box_ff;
   logic            scale_ff;

   // control state
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    j_ff;
   logic [PAIR_W-1:0]   pair_total_ff;
   logic [BIN_W-1:0]    k_ff;
   logic [MAX_BINS-1:0] bin_vld_ff;
   logic                last_ff;

   // particle stores
   logic [31:0] x_mem [MAX_PARTICLES];
   logic [31:0] y_mem [MAX_PARTICLES];
   logic [23:0] d_mem [MAX_PARTICLES];
   logic [PAIR_W-1:0] bin_mem [MAX_BINS];

   // payload
   logic [31:0]       x_ff, y_ff, sx_ff, sy_ff;
   logic [23:0]       diam_ff, sd_ff;
   logic [32:0]       dx_abs_ff, dy_abs_ff;
   logic              dx_neg_ff, dy_neg_ff;
   logic [24:0]       dsum_ff;
   logic [30:0]       ax_ff, ay_ff;
   logic [61:0]       sq_x_ff, sq_y_ff;
   logic [31:0]       dist_ff;
   logic [38:0]       bin_prod_ff;
   logic [BIN_W-1:0]  bin_idx_ff;
   logic              bin_ok_ff;
   logic [PAIR_W-1:0] cnt_rd_ff;
   logic              cnt_vld_ff;
   logic [BIN_W-1:0]  rsp_bin_ff;
   logic [31:0]       rsp_frac_ff;
   logic              rsp_last_ff;

   // combinational
   logic [30:0]          box_eff;
   logic [NB_W-1:0]      nb_eff;
   logic [32:0]          dx_in, dy_in;
   logic [PAIR_W-1:0]    bin_val;
   logic [BIN_W-1:0]     rd_addr;
   logic [63:0]          div_dvd;
   logic [31:0]          div_dsr;
   logic [DIV_CNT_W-1:0] div_steps;
   logic [63:0]          div_quo;
   logic [31:0]          div_rem;
   logic                 div_busy;
   logic                 div_done;
   logic [31:0]          sqrt_root;
   logic                 sqrt_done;
   logic [31:0]          dist_diff;
   logic                 k_last;
   logic                 store_room;

   function automatic logic [30:0] fold_axis(input logic [30:0] m, input logic neg,
                                             input logic [30:0] box);
      logic [30:0] r;
      logic [30:0] br;
      r  = (neg && m != '0) ? box - m : m;
      br = box - r;
      return (r < br) ? r : br;
   endfunction

   assign box_eff = (box_ff == '0) ? 31'd1 : box_ff;
   assign nb_eff  = (num_bins_ff == '0) ? NB_W'(1) :
                    (num_bins_ff > NB_MAX) ? NB_MAX : num_bins_ff;
   assign dx_in   = {x_ff[31], x_ff} - {sx_ff[31], sx_ff};
   assign dy_in   = {y_ff[31], y_ff} - {sy_ff[31], sy_ff};
   assign bin_val = cnt_vld_ff ? cnt_rd_ff : '0;
   assign rd_addr = cmd.rd_read ? k_ff : bin_idx_ff;
   assign dist_diff = dist_ff - {1'b0, range_min_ff};
   assign k_last  = ({{(NB_W-BIN_W){1'b0}}, k_ff} == nb_eff - NB_W'(1));
   assign store_room = count_ff < CNT_W'(MAX_PARTICLES);

   // divider operand selection
   always_comb begin
      div_dvd   = '0;
      div_dsr   = '0;
      div_steps = '0;
      unique case (cmd.div_sel)
         DIV_MODX: begin
            div_dvd   = {dx_abs_ff, 31'd0};
            div_dsr   = {1'b0, box_eff};
            div_steps = DIV_STEPS_MOD;
         end
         DIV_MODY: begin
            div_dvd   = {dy_abs_ff, 31'd0};
            div_dsr   = {1'b0, box_eff};
            div_steps = DIV_STEPS_MOD;
         end
         DIV_SCALE: begin
            div_dvd   = {dist_ff, 32'd0};
            div_dsr   = {7'd0, dsum_ff};
            div_steps = DIV_STEPS_SCALE;
         end
         DIV_BIN: begin
            div_dvd   = {bin_prod_ff, 25'd0};
            div_dsr   = {1'b0, range_max_ff - range_min_ff};
            div_steps = DIV_STEPS_BIN;
         end
         DIV_FRAC: begin
            div_dvd   = {bin_val, 44'd0};
            div_dsr   = {12'd0, pair_total_ff};
            div_steps = DIV_STEPS_FRAC;
         end
         default: ;
      endcase
   end

   pdh_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .steps     (div_steps),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   pdh_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .value ({1'b0, sq_x_ff} + {1'b0, sq_y_ff}),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_bins_ff  <= NUM_BINS_RST;
         range_min_ff <= RANGE_MIN_RST;
         range_max_ff <= RANGE_MAX_RST;
         box_ff       <= BOX_SIZE_RST;
         scale_ff     <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_NUM_BINS:   num_bins_ff  <= csr_wdata[NB_W-1:0];
            CSR_RANGE_MIN:  range_min_ff <= csr_wdata[30:0];
            CSR_RANGE_MAX:  range_max_ff <= csr_wdata[30:0];
            CSR_BOX_SIZE:   box_ff       <= csr_wdata[30:0];
            CSR_SCALE_DIAM: scale_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         j_ff          <= '0;
         pair_total_ff <= '0;
         k_ff          <= '0;
         bin_vld_ff    <= '0;
         last_ff       <= 1'b0;
      end else begin
         if (cmd.accept) begin
            j_ff    <= '0;
            last_ff <= req_last_particle;
         end
         if (cmd.next_j) begin
            j_ff <= j_ff + CNT_W'(1);
         end
         if (cmd.cap_dist && pair_total_ff != PAIR_MAX) begin
            pair_total_ff <= pair_total_ff + PAIR_W'(1);
         end
         if (cmd.bin_wr && bin_ok_ff) begin
            bin_vld_ff[bin_idx_ff] <= 1'b1;
         end
         if (cmd.store_done && store_room) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.rd_start) begin
            k_ff <= '0;
         end
         if (cmd.next_k) begin
            k_ff <= k_ff + BIN_W'(1);
         end
         if (cmd.clear_all) begin
            count_ff      <= '0;
            j_ff          <= '0;
            pair_total_ff <= '0;
            bin_vld_ff    <= '0;
         end
      end
   end

   // particle stores
   always_ff @(posedge clock) begin
      if (cmd.accept && store_room) begin
         x_mem[count_ff[ADDR_W-1:0]] <= req_pos_x;
         y_mem[count_ff[ADDR_W-1:0]] <= req_pos_y;
         d_mem[count_ff[ADDR_W-1:0]] <= req_diameter;
      end
      if (cmd.read_store) begin
         sx_ff <= x_mem[j_ff[ADDR_W-1:0]];
         sy_ff <= y_mem[j_ff[ADDR_W-1:0]];
         sd_ff <= d_mem[j_ff[ADDR_W-1:0]];
      end
   end

   // histogram memory, read-modify-write
   always_ff @(posedge clock) begin
      if (cmd.bin_rd || cmd.rd_read) begin
         cnt_rd_ff  <= bin_mem[rd_addr];
         cnt_vld_ff <= bin_vld_ff[rd_addr];
      end
      if (cmd.bin_wr && bin_ok_ff) begin
         bin_mem[bin_idx_ff] <= (bin_val != PAIR_MAX) ? bin_val + PAIR_W'(1) : bin_val;
      end
   end

   // pair arithmetic
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff    <= req_pos_x;
         y_ff    <= req_pos_y;
         diam_ff <= req_diameter;
      end
      if (cmd.load_pair) begin
         dx_neg_ff <= dx_in[32];
         dy_neg_ff <= dy_in[32];
         dx_abs_ff <= dx_in[32] ? (~dx_in + 33'd1) : dx_in;
         dy_abs_ff <= dy_in[32] ? (~dy_in + 33'd1) : dy_in;
         dsum_ff   <= {1'b0, diam_ff} + {1'b0, sd_ff};
      end
      if (cmd.cap_ax) begin
         ax_ff <= fold_axis(div_rem[30:0], dx_neg_ff, box_eff);
      end
      if (cmd.cap_ay) begin
         ay_ff <= fold_axis(div_rem[30:0], dy_neg_ff, box_eff);
      end
      if (cmd.mul) begin
         sq_x_ff <= 62'(ax_ff) * 62'(ax_ff);
         sq_y_ff <= 62'(ay_ff) * 62'(ay_ff);
      end
      if (cmd.cap_dist) begin
         dist_ff <= cmd.dist_sat ? '1 : sqrt_root;
      end
      if (cmd.cap_scaled) begin
         dist_ff <= (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
      end
      if (cmd.bin_prep) begin
         bin_prod_ff <= {7'd0, dist_diff} * {32'd0, nb_eff};
      end
      if (cmd.cap_bin) begin
         bin_ok_ff  <= (div_quo[63:NB_W] == '0) && (div_quo[NB_W-1:0] < nb_eff);
         bin_idx_ff <= div_quo[BIN_W-1:0];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.rsp_zero || cmd.rsp_load) begin
         rsp_bin_ff  <= k_ff;
         rsp_last_ff <= k_last;
         rsp_frac_ff <= cmd.rsp_load ? div_quo[31:0] : '0;
      end
   end

   assign rsp_bin_number    = rsp_bin_ff;
   assign rsp_pair_fraction = rsp_frac_ff;
   assign rsp_last_bin      = rsp_last_ff;

   assign sts.j_done     = j_ff >= count_ff;
   assign sts.div_done   = div_done;
   assign sts.sqrt_done  = sqrt_done;
   assign sts.scale_div  = scale_ff && (dsum_ff != '0);
   assign sts.scale_zero = scale_ff && (dsum_ff == '0);
   assign sts.in_range   = (range_max_ff > range_min_ff) && (dist_ff >= {1'b0, range_min_ff});
   assign sts.last       = last_ff;
   assign sts.pairs_zero = pair_total_ff == '0;
   assign sts.k_last     = k_last;

   `ASSERT_IMPLIES(a_j_bound, clock, reset, 1'b1, j_ff <= count_ff)
   `ASSERT_IMPLIES(a_div_idle_start, clock, reset, cmd.div_start, !div_busy)
   `ASSERT_IMPLIES(a_bin_idx_ok, clock, reset, cmd.bin_wr && bin_ok_ff, NB_W'(bin_idx_ff) < nb_eff)
   `ASSERT_NEXT(a_clear_empties, clock, reset, cmd.clear_all, count_ff == '0 && pair_total_ff == '0)

endmodule
`default_nettype wire

// ===== rtl/pdh_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdh_controller
// Sequencer for pairing, binning and histogram readout.
// ----------------------------------------------------------------------------
module pdh_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  pdh_pkg::sts_type sts,
   output pdh_pkg::cmd_type cmd
);
   import pdh_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.j_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.read_store = 1'b1;
               state_in       = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_pair = 1'b1;
            state_in      = ST_MODX;
         end
         ST_MODX: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MODX;
            state_in      = ST_MODX_WAIT;
         end
         ST_MODX_WAIT: begin
            if (sts.div_done) begin
               cmd.cap_ax = 1'b1;
               state_in   = ST_MODY;
            end
         end
         ST_MODY: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MODY;
            state_in      = ST_MODY_WAIT;
         end
         ST_MODY_WAIT: begin
            if (sts.div_done) begin
               cmd.cap_ay = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (sts.sqrt_done) begin
               cmd.cap_dist = 1'b1;
               cmd.dist_sat = sts.scale_zero;
               state_in     = sts.scale_div ? ST_SCALE : ST_BIN_CHECK;
            end
         end
         ST_SCALE: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SCALE;
            state_in      = ST_SCALE_WAIT;
         end
         ST_SCALE_WAIT: begin
            if (sts.div_done) begin
               cmd.cap_scaled = 1'b1;
               state_in       = ST_BIN_CHECK;
            end
         end
         ST_BIN_CHECK: begin
            if (sts.in_range) begin
               cmd.bin_prep = 1'b1;
               state_in     = ST_BIN_DIV;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_BIN_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_BIN;
            state_in      = ST_BIN_WAIT;
         end
         ST_BIN_WAIT: begin
            if (sts.div_done) begin
               cmd.cap_bin = 1'b1;
               state_in    = ST_BIN_READ;
            end
         end
         ST_BIN_READ: begin
            cmd.bin_rd = 1'b1;
            state_in   = ST_BIN_WRITE;
         end
         ST_BIN_WRITE: begin
            cmd.bin_wr = 1'b1;
            state_in   = ST_NEXT;
         end
         ST_NEXT: begin
            cmd.next_j = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_FINISH: begin
            cmd.store_done = 1'b1;
            if (sts.last) begin
               cmd.rd_start = 1'b1;
               state_in     = ST_RD_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_READ: begin
            cmd.rd_read = 1'b1;
            state_in    = ST_RD_DIV;
         end
         ST_RD_DIV: begin
            // no pairs seen: every bin reports zero
            if (sts.pairs_zero) begin
               cmd.rsp_zero = 1'b1;
               state_in     = ST_RD_OUT;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_FRAC;
               state_in      = ST_RD_WAIT;
            end
         end
         ST_RD_WAIT: begin
            if (sts.div_done) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_RD_OUT;
            end
         end
         ST_RD_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (sts.k_last) begin
                  cmd.clear_all = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.next_k = 1'b1;
                  state_in   = ST_RD_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/pair_distance_histogram.sv =====
// ----------------------------------------------------------------------------
// pair_distance_histogram: one request at a time; each is paired with every stored particle,
// plus a bin divide per pair in range, one more with diameter scaling (bit-serial divide/root)
// readout after the last particle: one response per bin, all zero if no pairs; rsp_ready stalls
// synchronous reset restores register defaults and empties the histogram via per-bin valid bits
// ----------------------------------------------------------------------------
`default_nettype none
module pair_distance_histogram (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [31:0]            req_pos_x,
   input  logic signed [31:0]            req_pos_y,
   input  logic [23:0]                   req_diameter,
   input  logic                          req_last_particle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pdh_pkg::BIN_W-1:0]     rsp_bin_number,
   output logic [31:0]                   rsp_pair_fraction,
   output logic                          rsp_last_bin,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pdh_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);
   import pdh_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   pdh_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pdh_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_wr            (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_diameter      (req_diameter),
      .req_last_particle (req_last_particle),
      .rsp_bin_number    (rsp_bin_number),
      .rsp_pair_fraction (rsp_pair_fraction),
      .rsp_last_bin      (rsp_last_bin)
   );

endmodule
`default_nettype wire
